/* design/mmic_pkg.sv */
// Shared types and constants for the magnetometer min/max iron calibration core.
`default_nettype none

package mmic_pkg;

  localparam int SAMPLE_BITS_DEF = 13;
  localparam int SCALE_FRAC_DEF  = 16;
  localparam int SCALE_INT_BITS  = 8;
  localparam int CAL_BITS        = 16;
  localparam int CAL_POS_MAX     = 32767;
  localparam int CAL_NEG_MAX     = 32768;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MUL_DONE,
    ST_DIV,
    ST_DIV_DONE
  } state_t;

  // Control from the sequencer to each axis lane
  typedef struct packed {
    logic load;
    logic step;
    logic div;
  } lane_ctrl_t;

endpackage

`default_nettype wire

/* design/mmic_lane.sv */
// One axis lane: bit-serial shift-add multiplier and restoring divider on shared registers.
`default_nettype none

module mmic_lane #(
  parameter int SAMPLE_BITS     = mmic_pkg::SAMPLE_BITS_DEF,
  parameter int SCALE_FRAC_BITS = mmic_pkg::SCALE_FRAC_DEF
) (
  input  wire logic                                       clk,
  input  wire mmic_pkg::lane_ctrl_t                       ctrl,
  input  wire logic [SAMPLE_BITS:0]                       opa,
  input  wire logic [SAMPLE_BITS+SCALE_FRAC_BITS:0]       load_lo,
  output logic [SAMPLE_BITS+mmic_pkg::SCALE_INT_BITS:0]   prod_mag,
  output logic [SAMPLE_BITS+SCALE_FRAC_BITS:0]            quot
);

  localparam int W    = SAMPLE_BITS + 1;
  localparam int LO_W = W + SCALE_FRAC_BITS;
  localparam int IW   = mmic_pkg::SCALE_INT_BITS;

  logic [W-1:0]    hi_r;
  logic [LO_W-1:0] lo_r;
  logic [W-1:0]    opa_r;

  logic [W:0]   add_sum;
  logic [W:0]   trial;
  logic [W:0]   sub_diff;
  logic         q_bit;
  logic [W-1:0] rem_nxt;

  always_comb begin
    // multiply: LSB of the multiplier selects an add, then shift right
    add_sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, opa_r} : '0);
    // divide: bring down next dividend bit, subtract if it fits
    trial    = {hi_r, lo_r[LO_W-1]};
    sub_diff = trial - {1'b0, opa_r};
    q_bit    = (trial >= {1'b0, opa_r});
    rem_nxt  = q_bit ? sub_diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hi_r  <= '0;
      lo_r  <= load_lo;
      opa_r <= opa;
    end else if (ctrl.step) begin
      if (ctrl.div) begin
        hi_r <= rem_nxt;
        lo_r <= {lo_r[LO_W-2:0], q_bit};
      end else begin
        hi_r <= add_sum[W:1];
        lo_r <= {add_sum[0], lo_r[LO_W-1:1]};
      end
    end
  end

  // product bits above the fraction: upper word plus the integer bits of the low word
  assign prod_mag = {hi_r, lo_r[LO_W-1 -: IW]};
  assign quot     = lo_r;

endmodule

`default_nettype wire

/* design/magnetometer_minmax_iron_calibration_core.sv */
// Sample item: accepted in idle, then a shift-add multiply over the scale bits, then the
//   output register is loaded, waiting there while the output is stalled.
// Stop item: a restoring divide over every dividend bit, then the scales are written.
// Start and unused opcodes complete at accept. One item in work at a time; the three axes run
//   in parallel bit-serial lanes, so a new item is accepted only once back in idle.
// Reset (synchronous, rst_n low) clears tracking, min/max, centers, scales and enables.
`default_nettype none

module magnetometer_minmax_iron_calibration_core #(
  parameter int SAMPLE_BITS     = mmic_pkg::SAMPLE_BITS_DEF,
  parameter int SCALE_FRAC_BITS = mmic_pkg::SCALE_FRAC_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,   // sample_x, sample_y, sample_z
  input  wire logic [1:0]                           in_tuser,   // opcode
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [3*mmic_pkg::CAL_BITS-1:0]           out_tdata,  // cal_x, cal_y, cal_z
  output logic [2:0]                                out_tuser   // hard_active, soft_active, saturated
);

  localparam int SB         = SAMPLE_BITS;
  localparam int W          = SB + 1;
  localparam int SCALE_BITS = mmic_pkg::SCALE_INT_BITS + SCALE_FRAC_BITS;
  localparam int LO_W       = W + SCALE_FRAC_BITS;
  localparam int MAG_W      = W + mmic_pkg::SCALE_INT_BITS;
  localparam int CNT_W      = $clog2(LO_W + 1);
  localparam int CW         = mmic_pkg::CAL_BITS;

  localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(1) << SCALE_FRAC_BITS;
  localparam logic [SCALE_BITS-1:0] SCALE_MAX = {SCALE_BITS{1'b1}};
  localparam logic [MAG_W-1:0]      POS_LIM   = MAG_W'(mmic_pkg::CAL_POS_MAX);
  localparam logic [MAG_W-1:0]      NEG_LIM   = MAG_W'(mmic_pkg::CAL_NEG_MAX);

  mmic_pkg::state_t     state_r, state_nxt;
  mmic_pkg::op_t        op;
  mmic_pkg::lane_ctrl_t ctrl;

  logic [CNT_W-1:0] cnt_r;
  logic             tracking_r, first_r, hard_en_r, soft_en_r;
  logic             maxspan_zero_r;
  logic             span_zero_r [3];
  logic             neg_r [3];
  logic signed [SB-1:0]  min_r [3];
  logic signed [SB-1:0]  max_r [3];
  logic signed [SB-1:0]  center_r [3];
  logic [SCALE_BITS-1:0] scale_r [3];

  logic            out_tvalid_r;
  logic [3*CW-1:0] out_tdata_r;
  logic [2:0]      out_tuser_r;

  logic in_fire, out_load, scale_wr, last_mul, last_div;

  logic signed [SB-1:0] smp [3];
  logic signed [W-1:0]  diff [3];
  logic signed [W-1:0]  csum [3];
  logic [W-1:0]         cadj [3];
  logic signed [W-1:0]  span_s [3];
  logic [W-1:0]         span [3];
  logic [W-1:0]         maxspan;
  logic [W-1:0]         mag_in [3];
  logic [W-1:0]         opa [3];
  logic [LO_W-1:0]      load_lo [3];
  logic [MAG_W-1:0]     prod [3];
  logic [LO_W-1:0]      quot [3];
  logic                 sat_ax [3];
  logic [CW-1:0]        cal [3];
  logic [SCALE_BITS-1:0] scale_fin [3];

  assign op       = mmic_pkg::op_t'(in_tuser);
  assign in_fire  = in_tvalid & in_tready;
  assign last_mul = (cnt_r == CNT_W'(SCALE_BITS - 1));
  assign last_div = (cnt_r == CNT_W'(LO_W - 1));

  // ---------------- per-axis datapath at accept ----------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      smp[i]    = in_tdata[i*SB +: SB];
      diff[i]   = {smp[i][SB-1], smp[i]}
                  - (hard_en_r ? {center_r[i][SB-1], center_r[i]} : W'(0));
      mag_in[i] = diff[i][W-1] ? W'(-diff[i]) : W'(diff[i]);
      // midpoint rounded toward zero: add one before the shift when negative
      csum[i]   = {min_r[i][SB-1], min_r[i]} + {max_r[i][SB-1], max_r[i]};
      cadj[i]   = csum[i] + W'(csum[i][W-1]);
      span_s[i] = {max_r[i][SB-1], max_r[i]} - {min_r[i][SB-1], min_r[i]};
      span[i]   = span_s[i][W-1] ? '0 : span_s[i];
    end
    maxspan = span[0];
    if (span[1] > maxspan) maxspan = span[1];
    if (span[2] > maxspan) maxspan = span[2];
    for (int i = 0; i < 3; i++) begin
      if (op == mmic_pkg::OP_STOP) begin
        opa[i]     = span[i];
        load_lo[i] = {maxspan, {SCALE_FRAC_BITS{1'b0}}};
      end else begin
        opa[i]     = mag_in[i];
        load_lo[i] = LO_W'(soft_en_r ? scale_r[i] : SCALE_ONE);
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    mmic_lane #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .ctrl    (ctrl),
      .opa     (opa[g]),
      .load_lo (load_lo[g]),
      .prod_mag(prod[g]),
      .quot    (quot[g])
    );
  end

  // ---------------- result shaping ----------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_ax[i] = neg_r[i] ? (prod[i] > NEG_LIM) : (prod[i] > POS_LIM);
      if (sat_ax[i])
        cal[i] = neg_r[i] ? CW'(mmic_pkg::CAL_NEG_MAX) : CW'(mmic_pkg::CAL_POS_MAX);
      else
        cal[i] = neg_r[i] ? -prod[i][CW-1:0] : prod[i][CW-1:0];
      if (maxspan_zero_r)
        scale_fin[i] = SCALE_ONE;
      else if (span_zero_r[i] || (quot[i][LO_W-1:SCALE_BITS] != '0))
        scale_fin[i] = SCALE_MAX;
      else
        scale_fin[i] = quot[i][SCALE_BITS-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mmic_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (op)
            mmic_pkg::OP_SAMPLE: state_nxt = mmic_pkg::ST_MUL;
            mmic_pkg::OP_STOP:   state_nxt = mmic_pkg::ST_DIV;
            default:             state_nxt = mmic_pkg::ST_IDLE;
          endcase
        end
      end
      mmic_pkg::ST_MUL:      if (last_mul) state_nxt = mmic_pkg::ST_MUL_DONE;
      mmic_pkg::ST_MUL_DONE: if (!out_tvalid_r || out_tready) state_nxt = mmic_pkg::ST_IDLE;
      mmic_pkg::ST_DIV:      if (last_div) state_nxt = mmic_pkg::ST_DIV_DONE;
      mmic_pkg::ST_DIV_DONE: state_nxt = mmic_pkg::ST_IDLE;
      default:               state_nxt = mmic_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == mmic_pkg::ST_IDLE);
    ctrl.load = in_fire && ((op == mmic_pkg::OP_SAMPLE) || (op == mmic_pkg::OP_STOP));
    ctrl.step = (state_r == mmic_pkg::ST_MUL) || (state_r == mmic_pkg::ST_DIV);
    ctrl.div  = (state_r == mmic_pkg::ST_DIV);
    out_load  = (state_r == mmic_pkg::ST_MUL_DONE) && (!out_tvalid_r || out_tready);
    scale_wr  = (state_r == mmic_pkg::ST_DIV_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mmic_pkg::ST_IDLE;
      cnt_r          <= '0;
      tracking_r     <= 1'b0;
      first_r        <= 1'b1;
      hard_en_r      <= 1'b0;
      soft_en_r      <= 1'b0;
      maxspan_zero_r <= 1'b0;
      out_tvalid_r   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        min_r[i]       <= '0;
        max_r[i]       <= '0;
        center_r[i]    <= '0;
        scale_r[i]     <= '0;
        span_zero_r[i] <= 1'b0;
        neg_r[i]       <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (ctrl.load)
        cnt_r <= '0;
      else if (ctrl.step)
        cnt_r <= cnt_r + CNT_W'(1);

      if (in_fire) begin
        case (op)
          mmic_pkg::OP_START: begin
            tracking_r <= 1'b1;
            first_r    <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              min_r[i] <= '0;
              max_r[i] <= '0;
            end
          end
          mmic_pkg::OP_STOP: begin
            maxspan_zero_r <= (maxspan == '0);
            for (int i = 0; i < 3; i++) begin
              center_r[i]    <= cadj[i][W-1:1];
              span_zero_r[i] <= (span[i] == '0);
            end
          end
          mmic_pkg::OP_SAMPLE: begin
            for (int i = 0; i < 3; i++) begin
              neg_r[i] <= diff[i][W-1];
              if (tracking_r) begin
                if (first_r || (smp[i] < min_r[i])) min_r[i] <= smp[i];
                if (first_r || (smp[i] > max_r[i])) max_r[i] <= smp[i];
              end
            end
            if (tracking_r) first_r <= 1'b0;
          end
          default: ;
        endcase
      end

      if (scale_wr) begin
        hard_en_r <= 1'b1;
        soft_en_r <= 1'b1;
        for (int i = 0; i < 3; i++)
          scale_r[i] <= scale_fin[i];
      end

      if (out_load)
        out_tvalid_r <= 1'b1;
      else if (out_tready)
        out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {cal[2], cal[1], cal[0]};
      out_tuser_r <= {sat_ax[0] | sat_ax[1] | sat_ax[2], soft_en_r, hard_en_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (min_r[0] <= max_r[0]) && (min_r[1] <= max_r[1]) && (min_r[2] <= max_r[2]))
    else $error("axis min above max");

  a_sample_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (op == mmic_pkg::OP_SAMPLE)) |=> (state_r == mmic_pkg::ST_MUL))
    else $error("sample item did not start the multiply");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmic_pkg::ST_MUL) |-> (cnt_r < CNT_W'(SCALE_BITS)))
    else $error("multiply step count overrun");

  a_stop_enables: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmic_pkg::ST_DIV_DONE) |=> (hard_en_r && soft_en_r))
    else $error("corrections not enabled after stop");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmic_pkg::ST_MUL_DONE && out_tvalid_r && !out_tready)
      |=> (state_r == mmic_pkg::ST_MUL_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire
